FILE: hdl/pca_pkg.sv
`timescale 1ns / 1ps
// pca_pkg: shared types and fixed widths for the pairwise concordance block
// used by pca_cell, pca_ratio and pairwise_concordance_auc_top; no dependencies

package pca_pkg;

    // fixed field widths
    localparam int IN_W      = 16;
    localparam int FRAC_BITS = 16;
    localparam int FRAC_W    = 17;
    localparam int CNT_W     = 19;
    localparam int QUO_W     = 17;
    localparam int STEP_W    = 5;
    localparam int DVD_W     = CNT_W + FRAC_BITS;
    localparam int TDATA_W   = 56;
    localparam int TUSER_W   = 2;

    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;
    localparam logic [CNT_W-1:0]  CNT_MAX  = 19'h7FFFF;

    // control flags of a token travelling down the chain
    typedef struct packed {
        logic valid;
        logic last;
        logic new_set;
        logic stored;
    } t_tok_ctl;

    // finished set totals handed to the ratio unit
    typedef struct packed {
        logic [CNT_W-1:0] pair;
        logic [CNT_W-1:0] agree;
        logic             overflow;
    } t_set_totals;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } t_div_state;

endpackage

FILE: hdl/pca_cell.sv
`timescale 1ns / 1ps
// pca_cell: one cell of the comparison chain, holds one stored item
// compares the passing token against it and forwards the token; uses pca_pkg

module pca_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int CW          = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  pca_pkg::t_tok_ctl      i_ctl,
    input  logic [SAMPLE_BITS-1:0] i_label,
    input  logic [SAMPLE_BITS-1:0] i_score,
    input  logic [CW-1:0]          i_pair,
    input  logic [CW-1:0]          i_agree,
    output pca_pkg::t_tok_ctl      o_ctl,
    output logic [SAMPLE_BITS-1:0] o_label,
    output logic [SAMPLE_BITS-1:0] o_score,
    output logic [CW-1:0]          o_pair,
    output logic [CW-1:0]          o_agree
);

    logic                   r_valid;
    logic [SAMPLE_BITS-1:0] r_lab_st;
    logic [SAMPLE_BITS-1:0] r_sco_st;
    pca_pkg::t_tok_ctl      r_ctl;
    pca_pkg::t_tok_ctl      n_ctl;
    logic [SAMPLE_BITS-1:0] r_lab;
    logic [SAMPLE_BITS-1:0] r_sco;
    logic [CW-1:0]          r_pc;
    logic [CW-1:0]          r_ac;
    logic [CW-1:0]          n_pc;
    logic [CW-1:0]          n_ac;

    logic w_eff;
    logic w_cmp;
    logic w_take;
    logic w_lgt;
    logic w_llt;
    logic w_sgt;
    logic w_slt;
    logic w_pair;
    logic w_agree;

    // a new set treats every cell it meets as empty
    assign w_eff  = r_valid & ~i_ctl.new_set;
    assign w_cmp  = i_ctl.valid & ~i_ctl.stored & w_eff;
    assign w_take = i_ctl.valid & ~i_ctl.stored & ~w_eff;

    // signs of stored minus passing, for label and score
    assign w_lgt = $signed(r_lab_st) > $signed(i_label);
    assign w_llt = $signed(r_lab_st) < $signed(i_label);
    assign w_sgt = $signed(r_sco_st) > $signed(i_score);
    assign w_slt = $signed(r_sco_st) < $signed(i_score);

    assign w_pair  = w_cmp & (w_lgt | w_llt);
    assign w_agree = w_pair & (w_lgt == w_sgt) & (w_llt == w_slt);

    // token update
    always_comb begin
        n_ctl        = i_ctl;
        n_ctl.stored = i_ctl.stored | w_take;
        n_pc         = i_pair + CW'(w_pair);
        n_ac         = i_agree + CW'(w_agree);
    end

    // control: token flags and stored-item valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl   <= '0;
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
            if (w_take) begin
                r_valid <= 1'b1;
            end else if (i_ctl.valid && i_ctl.new_set) begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload: passing token and stored item
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lab <= i_label;
            r_sco <= i_score;
            r_pc  <= n_pc;
            r_ac  <= n_ac;
            if (w_take) begin
                r_lab_st <= i_label;
                r_sco_st <= i_score;
            end
        end
    end

    assign o_ctl   = r_ctl;
    assign o_label = r_lab;
    assign o_score = r_sco;
    assign o_pair  = r_pc;
    assign o_agree = r_ac;

    // a stored item is only dropped by the first beat of a new set
    a_clear_by_new_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_valid) && $past(i_rst_n) |->
            $past(i_en && i_ctl.valid && i_ctl.new_set))
        else $error("cell valid dropped without a new set passing");

endmodule

FILE: hdl/pca_ratio.sv
`timescale 1ns / 1ps
// pca_ratio: bit-serial divider for the concordant fraction and result register
// takes set totals from the chain end, drives the master beat; uses pca_pkg

module pca_ratio (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  pca_pkg::t_set_totals          i_totals,
    output logic                          o_busy,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [pca_pkg::TDATA_W-1:0]   o_m_tdata,
    output logic [pca_pkg::TUSER_W-1:0]   o_m_tuser
);

    pca_pkg::t_div_state r_state;
    pca_pkg::t_div_state n_state;

    logic [pca_pkg::CNT_W-1:0]  r_div;
    logic [pca_pkg::CNT_W-1:0]  r_agree;
    logic                       r_ovf;
    logic [pca_pkg::CNT_W-1:0]  r_rem;
    logic [pca_pkg::QUO_W-1:0]  r_low;
    logic [pca_pkg::QUO_W-1:0]  r_quo;
    logic [pca_pkg::STEP_W-1:0] r_step;

    logic                        r_out_valid;
    logic [pca_pkg::FRAC_W-1:0]  r_frac;
    logic [pca_pkg::CNT_W-1:0]   r_pc;
    logic [pca_pkg::CNT_W-1:0]   r_ac;
    logic                        r_nop;
    logic                        r_oovf;

    logic [pca_pkg::DVD_W-1:0]   w_dvd;
    logic [pca_pkg::CNT_W:0]     w_shift;
    logic                        w_ge;
    logic [pca_pkg::CNT_W:0]     w_diff;
    logic [pca_pkg::CNT_W-1:0]   w_rem_nxt;
    logic                        w_last_step;
    logic                        w_load;

    // dividend is agree scaled by 2^16 plus half the divisor, for round-half-up
    assign w_dvd = {i_totals.agree, {pca_pkg::FRAC_BITS{1'b0}}}
                 + pca_pkg::DVD_W'(i_totals.pair >> 1);

    // one restoring step per cycle
    assign w_shift     = {r_rem, r_low[pca_pkg::QUO_W-1]};
    assign w_ge        = w_shift >= {1'b0, r_div};
    assign w_diff      = w_shift - {1'b0, r_div};
    assign w_rem_nxt   = w_ge ? w_diff[pca_pkg::CNT_W-1:0] : w_shift[pca_pkg::CNT_W-1:0];
    assign w_last_step = r_step == pca_pkg::STEP_W'(pca_pkg::QUO_W - 1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pca_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = pca_pkg::S_DIV;
                end
            end
            pca_pkg::S_DIV: begin
                if (w_last_step) begin
                    n_state = pca_pkg::S_HOLD;
                end
            end
            pca_pkg::S_HOLD: begin
                if (w_load) begin
                    n_state = pca_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pca_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_busy = 1'b1;
        w_load = 1'b0;
        case (r_state)
            pca_pkg::S_IDLE: begin
                o_busy = 1'b0;
            end
            pca_pkg::S_DIV: begin
                o_busy = 1'b1;
            end
            pca_pkg::S_HOLD: begin
                w_load = ~r_out_valid | i_m_tready;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pca_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // divider datapath
    always_ff @(posedge i_clk) begin
        if (r_state == pca_pkg::S_IDLE && i_start) begin
            r_div   <= i_totals.pair;
            r_agree <= i_totals.agree;
            r_ovf   <= i_totals.overflow;
            r_rem   <= pca_pkg::CNT_W'(w_dvd[pca_pkg::DVD_W-1:pca_pkg::QUO_W]);
            r_low   <= w_dvd[pca_pkg::QUO_W-1:0];
            r_quo   <= '0;
            r_step  <= '0;
        end else if (r_state == pca_pkg::S_DIV) begin
            r_rem  <= w_rem_nxt;
            r_low  <= {r_low[pca_pkg::QUO_W-2:0], 1'b0};
            r_quo  <= {r_quo[pca_pkg::QUO_W-2:0], w_ge};
            r_step <= r_step + 1'b1;
        end
    end

    // result register, empty pair set forces fraction to zero
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_frac <= (r_div == '0) ? '0 : r_quo;
            r_pc   <= r_div;
            r_ac   <= r_agree;
            r_nop  <= r_div == '0;
            r_oovf <= r_ovf;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_ac, r_pc, r_frac};
    assign o_m_tuser  = {r_oovf, r_nop};

    a_start_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_state == pca_pkg::S_DIV)
        else $error("start did not enter divide");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_frac <= pca_pkg::FRAC_ONE)
        else $error("fraction above one");

    a_agree_le_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_ac <= r_pc)
        else $error("concordant count above pair count");

endmodule

FILE: hdl/pairwise_concordance_auc_top.sv
`timescale 1ns / 1ps
// pairwise_concordance_auc_top: chain of pca_cell comparison cells, set totals
// and the pca_ratio divider; uses pca_pkg
//
//  channel  dir  tdata (low bit up)                         tuser / tlast
//  s        in   item_label[15:0], pred_score[31:16]        tlast = last_item
//  m        out  auc_fraction[16:0], pair_count[35:17],     tuser[0] = no_pairs,
//                concordant_count[54:36], zero pad [55]     tuser[1] = set_overflow
//
// one input beat per cycle while o_s_tready is high; each beat walks the MAX_ITEMS cells
// one per cycle while the chain advances, comparing with the item held in each and
// settling into the first free cell. after its last beat, a set result goes through the
// chain walk, the divider load, 17 divide steps and the output register.
// reset clears the chain tokens, the cell valid bits, the totals and the divider.
// input stalls only while a last beat waits at the chain end for the divider or
// output register of the previous set; master stalls back up through that path.

module pairwise_concordance_auc_top #(
    parameter int MAX_ITEMS   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [31:0]                   i_s_tdata,  // item_label, pred_score
    input  logic                          i_s_tlast,  // last_item
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [pca_pkg::TDATA_W-1:0]   o_m_tdata,  // auc_fraction, pair_count,
                                                      // concordant_count, pad
    output logic [pca_pkg::TUSER_W-1:0]   o_m_tuser   // no_pairs, set_overflow
);

    localparam int CW = $clog2(MAX_ITEMS);

    pca_pkg::t_tok_ctl      w_ctl [0:MAX_ITEMS];
    logic [SAMPLE_BITS-1:0] w_lab [0:MAX_ITEMS];
    logic [SAMPLE_BITS-1:0] w_sco [0:MAX_ITEMS];
    logic [CW-1:0]          w_pc  [0:MAX_ITEMS];
    logic [CW-1:0]          w_ac  [0:MAX_ITEMS];

    pca_pkg::t_tok_ctl      w_end;
    logic [CW-1:0]          w_end_pc;
    logic [CW-1:0]          w_end_ac;
    logic                   w_en;
    logic                   w_busy;
    logic                   w_consume;
    logic                   w_start;

    logic                   r_set_start;
    logic [pca_pkg::CNT_W-1:0] r_pair;
    logic [pca_pkg::CNT_W-1:0] r_agree;
    logic                   r_ovf;

    logic [pca_pkg::CNT_W:0]   w_pair_sum;
    logic [pca_pkg::CNT_W:0]   w_agree_sum;
    logic [pca_pkg::CNT_W-1:0] w_pair_new;
    logic [pca_pkg::CNT_W-1:0] w_agree_new;
    logic [CW-1:0]             w_pc_add;
    logic [CW-1:0]             w_ac_add;
    pca_pkg::t_set_totals      w_totals;

    // chain advances unless a last beat waits for the divider
    assign w_en       = ~(w_end.valid & w_end.last & w_busy);
    assign o_s_tready = w_en;

    // chain entry
    always_comb begin
        w_ctl[0].valid   = i_s_tvalid & w_en;
        w_ctl[0].last    = i_s_tlast;
        w_ctl[0].new_set = r_set_start;
        w_ctl[0].stored  = 1'b0;
        w_lab[0]         = SAMPLE_BITS'(i_s_tdata[15:0]);
        w_sco[0]         = SAMPLE_BITS'(i_s_tdata[31:16]);
        w_pc[0]          = '0;
        w_ac[0]          = '0;
    end

    // row of cells
    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        pca_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .CW          (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[g]),
            .i_label (w_lab[g]),
            .i_score (w_sco[g]),
            .i_pair  (w_pc[g]),
            .i_agree (w_ac[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_label (w_lab[g+1]),
            .o_score (w_sco[g+1]),
            .o_pair  (w_pc[g+1]),
            .o_agree (w_ac[g+1])
        );
    end

    assign w_end    = w_ctl[MAX_ITEMS];
    assign w_end_pc = w_pc[MAX_ITEMS];
    assign w_end_ac = w_ac[MAX_ITEMS];

    assign w_consume = w_en & w_end.valid;
    assign w_start   = w_consume & w_end.last;

    // a beat that found no free cell was dropped, its counts are ignored
    assign w_pc_add = w_end.stored ? w_end_pc : '0;
    assign w_ac_add = w_end.stored ? w_end_ac : '0;

    // saturating set totals
    assign w_pair_sum  = {1'b0, r_pair} + (pca_pkg::CNT_W + 1)'(w_pc_add);
    assign w_agree_sum = {1'b0, r_agree} + (pca_pkg::CNT_W + 1)'(w_ac_add);
    assign w_pair_new  = w_pair_sum[pca_pkg::CNT_W] ? pca_pkg::CNT_MAX
                                                    : w_pair_sum[pca_pkg::CNT_W-1:0];
    assign w_agree_new = w_agree_sum[pca_pkg::CNT_W] ? pca_pkg::CNT_MAX
                                                     : w_agree_sum[pca_pkg::CNT_W-1:0];

    always_comb begin
        w_totals.pair     = w_pair_new;
        w_totals.agree    = w_agree_new;
        w_totals.overflow = r_ovf | ~w_end.stored;
    end

    // set start flag and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_start <= 1'b1;
            r_pair      <= '0;
            r_agree     <= '0;
            r_ovf       <= 1'b0;
        end else begin
            if (i_s_tvalid && w_en) begin
                r_set_start <= i_s_tlast;
            end
            if (w_consume) begin
                if (w_end.last) begin
                    r_pair  <= '0;
                    r_agree <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_pair  <= w_totals.pair;
                    r_agree <= w_totals.agree;
                    r_ovf   <= w_totals.overflow;
                end
            end
        end
    end

    // fraction divider and output register
    pca_ratio u_ratio (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_totals   (w_totals),
        .o_busy     (w_busy),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    a_last_starts_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> w_busy)
        else $error("last beat at chain end did not start the divider");

    a_stall_holds_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |=> $stable(w_end_pc) && $stable(w_end_ac) && w_end.last)
        else $error("chain end token moved during stall");

endmodule
